// ===== design/cpg_pkg.sv =====
package cpg_pkg;

  localparam int PHASE_BITS   = 16;
  localparam int POS_BITS     = 24;
  localparam int ANGLE_BITS   = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int GAIN_Q       = 24;
  localparam int GAIN_INV     = 10188014;
  localparam int GAIN_W       = GAIN_Q + 1;
  localparam int GUARD_BITS   = 36 - POS_BITS;
  localparam int XW           = POS_BITS + GUARD_BITS + 3;
  localparam int LO_W         = XW / 2;
  localparam int HI_W         = XW - LO_W;
  localparam int PROD_W       = XW + GAIN_W;
  localparam int CTR_W        = POS_BITS + 1;
  localparam int RX_W         = POS_BITS + 4;
  localparam int SUM_W        = POS_BITS + 5;
  localparam int CFG_W        = (POS_BITS > PHASE_BITS) ? POS_BITS : PHASE_BITS;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd2;

  localparam logic ACTION_TICK  = 1'b0;
  localparam logic ACTION_START = 1'b1;

  localparam logic signed [GAIN_W-1:0] GAIN = GAIN_W'(GAIN_INV);

  typedef struct packed {
    logic                       action;
    logic signed [POS_BITS-1:0] start_x;
    logic signed [POS_BITS-1:0] start_y;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] point_x;
    logic signed [POS_BITS-1:0] point_y;
  } point_beat_t;

  typedef struct packed {
    logic                         valid;
    logic signed [XW-1:0]         x;
    logic signed [XW-1:0]         y;
    logic signed [ANGLE_BITS-1:0] z;
  } cell_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [ANGLE_BITS-1:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [ANGLE_BITS-1:0] v;
    case (idx)
      4'd0:    v = 32'd536870912;
      4'd1:    v = 32'd316933406;
      4'd2:    v = 32'd167458907;
      4'd3:    v = 32'd85004756;
      4'd4:    v = 32'd42667331;
      4'd5:    v = 32'd21354465;
      4'd6:    v = 32'd10679838;
      4'd7:    v = 32'd5340245;
      4'd8:    v = 32'd2670163;
      4'd9:    v = 32'd1335087;
      4'd10:   v = 32'd667544;
      4'd11:   v = 32'd333772;
      4'd12:   v = 32'd166886;
      4'd13:   v = 32'd83443;
      4'd14:   v = 32'd41722;
      4'd15:   v = 32'd20861;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/cpg_cordic_cell.sv =====
module cpg_cordic_cell
  import cpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cell_t                 din,
  input  logic [STEP_W-1:0]     shift,
  input  logic [ANGLE_BITS-1:0] atan,
  output cell_t                 dout
);

  logic signed [XW-1:0]         xs;
  logic signed [XW-1:0]         ys;
  logic signed [XW-1:0]         x_next;
  logic signed [XW-1:0]         y_next;
  logic signed [ANGLE_BITS-1:0] z_next;

  always_comb begin
    xs = din.x >>> shift;
    ys = din.y >>> shift;
    if (!din.z[ANGLE_BITS-1]) begin
      x_next = din.x - ys;
      y_next = din.y + xs;
      z_next = din.z - $signed(atan);
    end else begin
      x_next = din.x + ys;
      y_next = din.y - xs;
      z_next = din.z + $signed(atan);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    dout.x <= x_next;
    dout.y <= y_next;
    dout.z <= z_next;
  end

endmodule

// ===== design/cpg_cordic_chain.sv =====
module cpg_cordic_chain
  import cpg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cell_t din,
  output cell_t dout
);

  cell_t stage [CORDIC_STEPS+1];

  assign stage[0] = din;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    cpg_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .din   (stage[i]),
      .shift (STEP_W'(i)),
      .atan  (atan_turn(STEP_W'(i))),
      .dout  (stage[i+1])
    );
  end

  assign dout = stage[CORDIC_STEPS];

endmodule

// ===== design/cpg_gain.sv =====
module cpg_gain
  import cpg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cell_t                   din,
  input  logic signed [CTR_W-1:0] center_x,
  input  logic signed [CTR_W-1:0] center_y,
  output logic                    res_valid,
  output point_beat_t             res
);

  localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1) << (GUARD_BITS + GAIN_Q - 1);
  localparam logic signed [SUM_W-1:0] POS_MAX =
    {{(SUM_W-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] POS_MIN =
    {{(SUM_W-POS_BITS+1){1'b1}}, {(POS_BITS-1){1'b0}}};

  logic                              mul_valid;
  logic signed [HI_W+GAIN_W-1:0]     mxh;
  logic signed [HI_W+GAIN_W-1:0]     myh;
  logic signed [LO_W+GAIN_W:0]       mxl;
  logic signed [LO_W+GAIN_W:0]       myl;
  logic signed [PROD_W-1:0]          px;
  logic signed [PROD_W-1:0]          py;
  logic signed [RX_W-1:0]            rx;
  logic signed [RX_W-1:0]            ry;
  logic signed [SUM_W-1:0]           sx;
  logic signed [SUM_W-1:0]           sy;
  logic signed [SUM_W-1:0]           qx;
  logic signed [SUM_W-1:0]           qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      mul_valid <= din.valid;
      res_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    mxh <= $signed(din.x[XW-1:LO_W]) * GAIN;
    myh <= $signed(din.y[XW-1:LO_W]) * GAIN;
    mxl <= $signed({1'b0, din.x[LO_W-1:0]}) * GAIN;
    myl <= $signed({1'b0, din.y[LO_W-1:0]}) * GAIN;
  end

  always_comb begin
    px = (PROD_W'(mxh) <<< LO_W) + PROD_W'(mxl) + ROUND;
    py = (PROD_W'(myh) <<< LO_W) + PROD_W'(myl) + ROUND;
    rx = px[PROD_W-1:GUARD_BITS+GAIN_Q];
    ry = py[PROD_W-1:GUARD_BITS+GAIN_Q];
    sx = SUM_W'(center_x) + SUM_W'(rx);
    sy = SUM_W'(center_y) + SUM_W'(ry);
    if (sx > POS_MAX) begin
      qx = POS_MAX;
    end else if (sx < POS_MIN) begin
      qx = POS_MIN;
    end else begin
      qx = sx;
    end
    if (sy > POS_MAX) begin
      qy = POS_MAX;
    end else if (sy < POS_MIN) begin
      qy = POS_MIN;
    end else begin
      qy = sy;
    end
  end

  always_ff @(posedge clk) begin
    res.point_x <= qx[POS_BITS-1:0];
    res.point_y <= qy[POS_BITS-1:0];
  end

endmodule

// ===== design/circular_path_point_generator.sv =====
// Channel   Direction  Handshake                Beat
// command   in         cmd_valid / cmd_stall    cmd_beat   (action, start_x, start_y)
// point     out        point_valid / point_stall point_beat (point_x, point_y)
// config    in         cfg_write                cfg_index, cfg_data
//
// A start beat produces no point and does not raise cmd_stall.
// A tick beat passes a quadrant stage, a 16-cell rotation chain and a two-stage gain
// multiply, and then the output register; cmd_stall stays high from acceptance until
// its point is loaded into the output register, so only one tick is in flight at a time.
// A finished point waits in a holding register while the output is stalled.
// Reset is synchronous and clears configuration, center, phase and all valid flags.
module circular_path_point_generator
  import cpg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_beat_t            cmd_beat,
  output logic                 point_valid,
  input  logic                 point_stall,
  output point_beat_t          point_beat,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;
  localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(1) << (ANGLE_BITS - 3);

  logic signed [POS_BITS-1:0]   offset_x;
  logic signed [POS_BITS-1:0]   offset_y;
  logic [PHASE_BITS-1:0]        phase_step;
  logic signed [CTR_W-1:0]      center_x;
  logic signed [CTR_W-1:0]      center_y;
  logic [PHASE_BITS-1:0]        phase_acc;
  logic                         busy;
  logic                         pend_valid;
  point_beat_t                  pend;
  cell_t                        head;
  cell_t                        tail;
  logic                         res_valid;
  point_beat_t                  res;

  logic                         accept;
  logic                         tick;
  logic                         out_free;
  logic signed [CTR_W-1:0]      nx;
  logic signed [CTR_W-1:0]      ny;
  logic signed [CTR_W+GUARD_BITS-1:0] gx;
  logic signed [CTR_W+GUARD_BITS-1:0] gy;
  logic signed [XW-1:0]         wx;
  logic signed [XW-1:0]         wy;
  logic [ANGLE_BITS-1:0]        angle;
  logic [ANGLE_BITS-1:0]        ang_sh;
  logic [1:0]                   quad;
  logic signed [XW-1:0]         x_next;
  logic signed [XW-1:0]         y_next;
  logic signed [ANGLE_BITS-1:0] z_next;

  assign cmd_stall = busy;
  assign accept    = cmd_valid && !busy;
  assign tick      = accept && (cmd_beat.action == ACTION_TICK);
  assign out_free  = !point_valid || !point_stall;

  always_comb begin
    nx     = -CTR_W'(offset_x);
    ny     = -CTR_W'(offset_y);
    gx     = {nx, {GUARD_BITS{1'b0}}};
    gy     = {ny, {GUARD_BITS{1'b0}}};
    wx     = XW'(gx);
    wy     = XW'(gy);
    angle  = ANGLE_BITS'(0) - {phase_acc, {(ANGLE_BITS-PHASE_BITS){1'b0}}};
    ang_sh = angle + EIGHTH;
    quad   = ang_sh[ANGLE_BITS-1:ANGLE_BITS-2];
    z_next = $signed({2'b00, ang_sh[ANGLE_BITS-3:0]}) - $signed(EIGHTH);
    case (quad)
      QUAD_0: begin
        x_next = wx;
        y_next = wy;
      end
      QUAD_1: begin
        x_next = -wy;
        y_next = wx;
      end
      QUAD_2: begin
        x_next = -wx;
        y_next = -wy;
      end
      QUAD_3: begin
        x_next = wy;
        y_next = -wx;
      end
      default: begin
        x_next = wx;
        y_next = wy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x   <= '0;
      offset_y   <= '0;
      phase_step <= '0;
      center_x   <= '0;
      center_y   <= '0;
      phase_acc  <= '0;
      head.valid <= 1'b0;
    end else begin
      head.valid <= tick;
      if (cfg_write) begin
        case (cfg_index)
          REG_OFFSET_X:   offset_x   <= cfg_data[POS_BITS-1:0];
          REG_OFFSET_Y:   offset_y   <= cfg_data[POS_BITS-1:0];
          REG_PHASE_STEP: phase_step <= cfg_data[PHASE_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (cmd_beat.action == ACTION_START) begin
          center_x  <= CTR_W'(cmd_beat.start_x) + CTR_W'(offset_x);
          center_y  <= CTR_W'(cmd_beat.start_y) + CTR_W'(offset_y);
          phase_acc <= phase_step;
        end else begin
          phase_acc <= phase_acc + phase_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    head.x <= x_next;
    head.y <= y_next;
    head.z <= z_next;
  end

  cpg_cordic_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .din  (head),
    .dout (tail)
  );

  cpg_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .din       (tail),
    .center_x  (center_x),
    .center_y  (center_y),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pend_valid  <= 1'b0;
      point_valid <= 1'b0;
    end else begin
      if (tick) begin
        busy <= 1'b1;
      end
      if (out_free) begin
        if (pend_valid) begin
          point_valid <= 1'b1;
          pend_valid  <= 1'b0;
          busy        <= 1'b0;
        end else if (res_valid) begin
          point_valid <= 1'b1;
          busy        <= 1'b0;
        end else begin
          point_valid <= 1'b0;
        end
      end else if (res_valid) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        point_beat <= pend;
      end else if (res_valid) begin
        point_beat <= res;
      end
    end else if (res_valid) begin
      pend <= res;
    end
  end

endmodule

// ===== tb/path_point_check.sv =====
module path_point_check
  import cpg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  logic                 cmd_stall,
  input  cmd_beat_t            cmd_beat,
  input  logic                 point_valid,
  input  logic                 point_stall,
  input  point_beat_t          point_beat,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };
  localparam longint POS_HI = (longint'(1) <<< (POS_BITS - 1)) - 1;
  localparam longint POS_LO = -(longint'(1) <<< (POS_BITS - 1));

  logic signed [POS_BITS-1:0] off_x, off_y;
  logic [PHASE_BITS-1:0]      step, phase;
  logic signed [CTR_W-1:0]    ctr_x, ctr_y;
  point_beat_t                due_points[$];

  function automatic void rotate_ccw(input longint vx, input longint vy,
                                     input logic [ANGLE_BITS-1:0] angle,
                                     output longint rx, output longint ry);
    logic [ANGLE_BITS-1:0] a;
    longint x, y, z, t, xs, ys;
    a = angle + 32'h2000_0000;
    z = longint'(a[ANGLE_BITS-3:0]) - 64'sh2000_0000;
    x = vx <<< GUARD_BITS;
    y = vy <<< GUARD_BITS;
    case (a[ANGLE_BITS-1 -: 2])
      2'd1: begin
        t = x; x = -y; y = t;
      end
      2'd2: begin
        x = -x; y = -y;
      end
      2'd3: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_TURNS[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_TURNS[i];
      end
    end
    t = longint'(1) <<< (GUARD_BITS + GAIN_Q - 1);
    rx = (x * GAIN_INV + t) >>> (GUARD_BITS + GAIN_Q);
    ry = (y * GAIN_INV + t) >>> (GUARD_BITS + GAIN_Q);
  endfunction

  function automatic longint clamp_pos(input longint v);
    return (v > POS_HI) ? POS_HI : ((v < POS_LO) ? POS_LO : v);
  endfunction

  // A clockwise turn by the phase is a counterclockwise turn by its negation.
  function automatic point_beat_t next_point();
    logic [ANGLE_BITS-1:0] angle;
    longint rx, ry;
    point_beat_t p;
    angle = {phase, {(ANGLE_BITS - PHASE_BITS){1'b0}}};
    angle = -angle;
    rotate_ccw(-longint'(off_x), -longint'(off_y), angle, rx, ry);
    p.point_x = POS_BITS'(clamp_pos(longint'(ctr_x) + rx));
    p.point_y = POS_BITS'(clamp_pos(longint'(ctr_y) + ry));
    return p;
  endfunction

  always @(posedge clk) begin
    point_beat_t want;
    if (rst) begin
      off_x = '0;
      off_y = '0;
      step = '0;
      phase = '0;
      ctr_x = '0;
      ctr_y = '0;
      due_points.delete();
      mismatches = 0;
    end else begin
      if (point_valid && !point_stall) begin
        if (due_points.size() == 0) begin
          $error("unexpected point beat: point_x=%0d point_y=%0d",
                 point_beat.point_x, point_beat.point_y);
          mismatches++;
        end else begin
          want = due_points.pop_front();
          if (point_beat.point_x !== want.point_x) begin
            $error("point_x: expected %0d, got %0d", want.point_x, point_beat.point_x);
            mismatches++;
          end
          if (point_beat.point_y !== want.point_y) begin
            $error("point_y: expected %0d, got %0d", want.point_y, point_beat.point_y);
            mismatches++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_OFFSET_X:   off_x = cfg_data[POS_BITS-1:0];
          REG_OFFSET_Y:   off_y = cfg_data[POS_BITS-1:0];
          REG_PHASE_STEP: step = cfg_data[PHASE_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_valid && !cmd_stall) begin
        if (cmd_beat.action == ACTION_START) begin
          ctr_x = CTR_W'(longint'(cmd_beat.start_x) + longint'(off_x));
          ctr_y = CTR_W'(longint'(cmd_beat.start_y) + longint'(off_y));
          phase = step;
        end else begin
          due_points.push_back(next_point());
          phase = phase + step;
        end
      end
    end
    pending = due_points.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cpg_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 205;
  localparam int SETTLE_CYCLES = 30;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS - 1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS - 1){1'b0}}};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  cmd_beat_t            cmd_beat = '0;
  logic                 point_valid;
  logic                 point_stall = 1'b0;
  point_beat_t          point_beat;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatches;
  int pending;
  int cycles = 0;
  int hold_left = 0;
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  circular_path_point_generator dut (.*);

  path_point_check path_check (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 4);
    return $urandom_range(16, 60);
  endfunction

  function automatic logic [POS_BITS-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return POS_MAX;
      1: return POS_MIN;
      2, 3: return POS_BITS'($urandom);
      default: return POS_BITS'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  function automatic logic [PHASE_BITS-1:0] rand_step();
    case ($urandom_range(0, 3))
      0: return PHASE_BITS'(int'($urandom_range(0, 128)) - 64);
      1: return PHASE_BITS'($urandom_range(0, 3)) << (PHASE_BITS - 2);
      default: return PHASE_BITS'($urandom);
    endcase
  endfunction

  always @(negedge clk) begin
    if (hold_left == 0 && !sink_quiet && $urandom_range(0, 3) == 0)
      hold_left = pick_gap();
    if (hold_left > 0) begin
      point_stall <= 1'b1;
      hold_left--;
    end else begin
      point_stall <= 1'b0;
    end
  end

  task automatic send_cmd(input logic action, input logic [POS_BITS-1:0] x,
                          input logic [POS_BITS-1:0] y);
    int gap;
    gap = (src_quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_beat <= '{action, x, y};
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic tick();
    send_cmd(ACTION_TICK, POS_BITS'($urandom), POS_BITS'($urandom));
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // Once every point is out nothing is in flight; the extra idle cycles keep
  // the register writes well apart from the last beat.
  task automatic load_settings(input logic [POS_BITS-1:0] ox, input logic [POS_BITS-1:0] oy,
                               input logic [PHASE_BITS-1:0] step);
    logic [CFG_W-1:0] d;
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    d = CFG_W'($urandom);
    d[PHASE_BITS-1:0] = step;
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_PHASE_STEP, d);
    if ($urandom_range(0, 1) == 0) write_reg(REG_SPARE, CFG_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  initial begin
    int sent;
    int n;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    load_settings(POS_BITS'(2560), POS_BITS'(-1280), 16'h4000);
    tick();
    send_cmd(ACTION_START, '0, '0);
    repeat (5) tick();
    load_settings(POS_MIN, POS_MAX, 16'h8000);
    send_cmd(ACTION_START, POS_MAX, POS_MIN);
    repeat (3) tick();
    load_settings(POS_MAX, POS_MIN, 16'h7FFF);
    send_cmd(ACTION_START, POS_MIN, POS_MAX);
    repeat (2) tick();
    send_cmd(ACTION_START, POS_BITS'(1000), POS_BITS'(-1000));
    tick();
    load_settings(POS_BITS'(-512), POS_BITS'(768), 16'h0001);
    repeat (2) tick();
    load_settings('0, '0, '0);
    send_cmd(ACTION_TICK, POS_MAX, POS_MAX);
    send_cmd(ACTION_START, POS_BITS'(-1), POS_BITS'(-1));
    tick();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: load_settings(POS_MAX, POS_MAX, 16'h7FFF);
        1: load_settings(POS_MIN, POS_MIN, 16'h8000);
        2: load_settings('0, '0, '0);
        default: load_settings(rand_pos(), rand_pos(), rand_step());
      endcase
      src_quiet = (p == 3) || ($urandom_range(0, 4) == 0);
      sink_quiet = (p == 3) || ($urandom_range(0, 4) == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0: begin
            n = $urandom_range(1, 4);
            repeat (n) tick();
            sent += n;
          end
          1: begin
            send_cmd(ACTION_START, rand_pos(), rand_pos());
            sent++;
          end
          2: drain();
          default: begin
            send_cmd(ACTION_START, rand_pos(), rand_pos());
            n = $urandom_range(1, 24);
            repeat (n) tick();
            sent += n + 1;
          end
        endcase
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/cpg_pkg.sv
design/cpg_cordic_cell.sv
design/cpg_cordic_chain.sv
design/cpg_gain.sv
design/circular_path_point_generator.sv
tb/path_point_check.sv
tb/testbench.sv
